@@ hdl/cctt_pkg.sv @@
`default_nettype none
package cctt_pkg;

    localparam int KEY_W  = 42;
    localparam int HASH_W = 32;
    localparam int POS_ENTRIES_DEF  = 256;
    localparam int HASH_ENTRIES_DEF = 256;

    typedef enum logic {
        CMD_CHECK = 1'b0,
        CMD_CLEAR = 1'b1
    } cmd_t;

    typedef struct packed {
        logic        command;
        logic [7:0]  sheet_id;
        logic [13:0] col_index;
        logic [19:0] row_index;
        logic [31:0] content_hash;
    } in_t;

    typedef struct packed {
        logic collect_req;
        logic table_full;
    } out_t;

    typedef enum logic [1:0] {
        P_LOOK  = 2'd0,
        P_INUSE = 2'd1,
        P_INS   = 2'd2
    } pos_op_t;

    typedef enum logic [1:0] {
        H_LOOK = 2'd0,
        H_REM  = 2'd1,
        H_INS  = 2'd2
    } hash_op_t;

    // Token that walks along the position chain, one cell per cycle.
    typedef struct packed {
        logic              vld;
        pos_op_t           op;
        logic              found;
        logic              free;
        logic [HASH_W-1:0] old;
    } pos_tok_t;

    typedef struct packed {
        logic     vld;
        hash_op_t op;
        logic     found;
    } hash_tok_t;

endpackage
`default_nettype wire

@@ hdl/cctt_pos_cell.sv @@
`default_nettype none
module cctt_pos_cell (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         clear,
    input  wire logic [cctt_pkg::KEY_W-1:0]   key,
    input  wire logic [cctt_pkg::HASH_W-1:0]  hash,
    input  wire cctt_pkg::pos_tok_t           tok_in,
    output cctt_pkg::pos_tok_t                tok_out
);
    import cctt_pkg::*;

    logic              valid_reg, valid_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [HASH_W-1:0] hash_reg, hash_next;
    pos_tok_t          tok_reg, tok_next;

    always_comb
    begin
        tok_next   = tok_in;
        valid_next = valid_reg;
        key_next   = key_reg;
        hash_next  = hash_reg;
        if (tok_in.vld)
        begin
            case (tok_in.op)
                P_LOOK:
                begin
                    if (!valid_reg)
                    begin
                        tok_next.free = 1'b1;
                    end
                    else if (key_reg == key && !tok_in.found)
                    begin
                        tok_next.found = 1'b1;
                        tok_next.old   = hash_reg;
                        hash_next      = hash;
                    end
                end
                P_INUSE:
                begin
                    if (valid_reg && hash_reg == tok_in.old)
                    begin
                        tok_next.found = 1'b1;
                    end
                end
                P_INS:
                begin
                    // The first free cell along the chain takes the new entry.
                    if (!valid_reg && !tok_in.found)
                    begin
                        tok_next.found = 1'b1;
                        valid_next     = 1'b1;
                        key_next       = key;
                        hash_next      = hash;
                    end
                end
                default:
                begin
                    tok_next = tok_in;
                end
            endcase
        end
        if (clear)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        hash_reg <= hash_next;
    end

    assign tok_out = tok_reg;

endmodule
`default_nettype wire

@@ hdl/cctt_hash_cell.sv @@
`default_nettype none
module cctt_hash_cell (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         clear,
    input  wire logic [cctt_pkg::HASH_W-1:0]  hash,
    input  wire logic [cctt_pkg::HASH_W-1:0]  old,
    input  wire cctt_pkg::hash_tok_t          tok_in,
    output cctt_pkg::hash_tok_t               tok_out
);
    import cctt_pkg::*;

    logic              valid_reg, valid_next;
    logic [HASH_W-1:0] entry_reg, entry_next;
    hash_tok_t         tok_reg, tok_next;

    always_comb
    begin
        tok_next   = tok_in;
        valid_next = valid_reg;
        entry_next = entry_reg;
        if (tok_in.vld)
        begin
            case (tok_in.op)
                H_LOOK:
                begin
                    if (valid_reg && entry_reg == hash)
                    begin
                        tok_next.found = 1'b1;
                    end
                end
                H_REM:
                begin
                    if (valid_reg && entry_reg == old)
                    begin
                        valid_next = 1'b0;
                    end
                end
                H_INS:
                begin
                    if (!valid_reg && !tok_in.found)
                    begin
                        tok_next.found = 1'b1;
                        valid_next     = 1'b1;
                        entry_next     = hash;
                    end
                end
                default:
                begin
                    tok_next = tok_in;
                end
            endcase
        end
        if (clear)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign tok_out = tok_reg;

endmodule
`default_nettype wire

@@ hdl/cell_content_change_tracker.sv @@
// Cell content change tracker.
// Input channel in_valid/in_ready carries one in_t item per transfer: either a
// check of a cell position against a content hash, or a clear of all tables.
// Output channel out_valid/out_ready returns exactly one out_t per item.
// Both tables are rows of cells; a token walks a row one cell per cycle. A
// check looks up both rows at once and then runs at most three more passes
// (use test, hash removal and hash insert, or position insert and hash
// insert). A clear skips the lookups and goes straight to the response
// state, which presents its result.
// One item is processed at a time; in_ready is high only while idle, so it
// returns in the cycle that the result appears.
// The result is held in an output register until taken, and the next item
// may be accepted meanwhile; its result waits if the receiver still stalls.
// Reset empties both tables at once and drops any pending result.
`default_nettype none
module cell_content_change_tracker #(
    parameter int POS_ENTRIES  = cctt_pkg::POS_ENTRIES_DEF,
    parameter int HASH_ENTRIES = cctt_pkg::HASH_ENTRIES_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire cctt_pkg::in_t  in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output cctt_pkg::out_t      out_data
);
    import cctt_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b00000001,
        S_LOOK   = 8'b00000010,
        S_DECIDE = 8'b00000100,
        S_INUSE  = 8'b00001000,
        S_REMOVE = 8'b00010000,
        S_PINS   = 8'b00100000,
        S_HINS   = 8'b01000000,
        S_RESP   = 8'b10000000
    } state_t;

    state_t            state_reg, state_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [HASH_W-1:0] hash_reg, hash_next;
    logic [HASH_W-1:0] old_reg, old_next;
    logic              found_reg, found_next;
    logic              pfree_reg, pfree_next;
    logic              known_reg, known_next;
    logic              full_reg, full_next;
    logic              pdone_reg, pdone_next;
    logic              hdone_reg, hdone_next;
    logic              clear_reg, clear_next;
    pos_tok_t          pinj_reg, pinj_next;
    hash_tok_t         hinj_reg, hinj_next;
    logic              out_valid_reg, out_valid_next;
    out_t              out_reg, out_next;

    pos_tok_t  ptok [POS_ENTRIES];
    hash_tok_t htok [HASH_ENTRIES];
    pos_tok_t  pend;
    hash_tok_t hend;

    genvar gi;
    generate
        for (gi = 0; gi < POS_ENTRIES; gi++)
        begin : g_pos
            cctt_pos_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .clear   (clear_reg),
                .key     (key_reg),
                .hash    (hash_reg),
                .tok_in  ((gi == 0) ? pinj_reg : ptok[(gi == 0) ? 0 : gi - 1]),
                .tok_out (ptok[gi])
            );
        end
        for (gi = 0; gi < HASH_ENTRIES; gi++)
        begin : g_hash
            cctt_hash_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .clear   (clear_reg),
                .hash    (hash_reg),
                .old     (old_reg),
                .tok_in  ((gi == 0) ? hinj_reg : htok[(gi == 0) ? 0 : gi - 1]),
                .tok_out (htok[gi])
            );
        end
    endgenerate

    assign pend = ptok[POS_ENTRIES-1];
    assign hend = htok[HASH_ENTRIES-1];

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        key_next       = key_reg;
        hash_next      = hash_reg;
        old_next       = old_reg;
        found_next     = found_reg;
        pfree_next     = pfree_reg;
        known_next     = known_reg;
        full_next      = full_reg;
        pdone_next     = pdone_reg;
        hdone_next     = hdone_reg;
        clear_next     = 1'b0;
        pinj_next      = '0;
        hinj_next      = '0;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    full_next  = 1'b0;
                    known_next = 1'b1;
                    if (in_data.command == CMD_CLEAR)
                    begin
                        clear_next = 1'b1;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        key_next   = {in_data.sheet_id, in_data.col_index, in_data.row_index};
                        hash_next  = in_data.content_hash;
                        pdone_next = 1'b0;
                        hdone_next = 1'b0;
                        pinj_next.vld = 1'b1;
                        pinj_next.op  = P_LOOK;
                        hinj_next.vld = 1'b1;
                        hinj_next.op  = H_LOOK;
                        state_next = S_LOOK;
                    end
                end
            end
            S_LOOK:
            begin
                if (pend.vld)
                begin
                    found_next = pend.found;
                    pfree_next = pend.free;
                    old_next   = pend.old;
                    pdone_next = 1'b1;
                end
                if (hend.vld)
                begin
                    known_next = hend.found;
                    hdone_next = 1'b1;
                end
                if (pdone_reg && hdone_reg)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                full_next = !found_reg && !pfree_reg;
                if (found_reg && old_reg != hash_reg)
                begin
                    pinj_next.vld = 1'b1;
                    pinj_next.op  = P_INUSE;
                    pinj_next.old = old_reg;
                    state_next    = S_INUSE;
                end
                else if (!found_reg && pfree_reg)
                begin
                    pinj_next.vld = 1'b1;
                    pinj_next.op  = P_INS;
                    state_next    = S_PINS;
                end
                else if (!known_reg)
                begin
                    hinj_next.vld = 1'b1;
                    hinj_next.op  = H_INS;
                    state_next    = S_HINS;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_INUSE:
            begin
                if (pend.vld)
                begin
                    if (!pend.found)
                    begin
                        hinj_next.vld = 1'b1;
                        hinj_next.op  = H_REM;
                        state_next    = S_REMOVE;
                    end
                    else if (!known_reg)
                    begin
                        hinj_next.vld = 1'b1;
                        hinj_next.op  = H_INS;
                        state_next    = S_HINS;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
            end
            S_REMOVE, S_PINS:
            begin
                if ((state_reg == S_REMOVE) ? hend.vld : pend.vld)
                begin
                    if (!known_reg)
                    begin
                        hinj_next.vld = 1'b1;
                        hinj_next.op  = H_INS;
                        state_next    = S_HINS;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
            end
            S_HINS:
            begin
                if (hend.vld)
                begin
                    full_next  = full_reg || !hend.found;
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next       = 1'b1;
                    out_next.collect_req = !known_reg;
                    out_next.table_full  = full_reg;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pdone_reg     <= 1'b0;
            hdone_reg     <= 1'b0;
            clear_reg     <= 1'b0;
            pinj_reg      <= '0;
            hinj_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pdone_reg     <= pdone_next;
            hdone_reg     <= hdone_next;
            clear_reg     <= clear_next;
            pinj_reg      <= pinj_next;
            hinj_reg      <= hinj_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        hash_reg  <= hash_next;
        old_reg   <= old_next;
        found_reg <= found_next;
        pfree_reg <= pfree_next;
        known_reg <= known_next;
        full_reg  <= full_next;
        out_reg   <= out_next;
    end

`ifndef SYNTHESIS
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second transfer accepted while an item is in progress");

    a_pos_single_token: assert property (@(posedge clk) disable iff (!rst_n)
        pinj_reg.vld |-> !pend.vld)
        else $error("two tokens on the position chain");

    a_hash_single_token: assert property (@(posedge clk) disable iff (!rst_n)
        hinj_reg.vld |-> !hend.vld)
        else $error("two tokens on the hash chain");

    a_out_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_RESP))
        else $error("result presented outside the response state");
`endif

endmodule
`default_nettype wire
